// ----- hw/rtl/gdfs_pkg.sv -----
// Shared types and constants for the depth-first search core.
// No dependencies.
package gdfs_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR_GRAPH = 2'd0,
    OP_ADD_EDGE    = 2'd1,
    OP_CLEAR_MARKS = 2'd2,
    OP_SEARCH      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_RESERVED  = 2'd3
  } status_t;

  localparam logic [0:0] REG_VERTEX_COUNT  = 1'b0;
  localparam logic [0:0] REG_DIRECTED_MODE = 1'b1;
  localparam logic [6:0] NO_PARENT = 7'h7F;

  typedef enum logic [3:0] {
    DC_NONE    = 4'd0,
    DC_WIPE    = 4'd1,  // clear lists and marks, one vertex a cycle
    DC_WIPEMK  = 4'd2,  // clear marks, one vertex a cycle
    DC_APPEND  = 4'd3,  // write one slot for (from,to)
    DC_LINK    = 4'd4,  // link tail / head for the appended slot
    DC_SRCMARK = 4'd5,  // mark source, push
    DC_TOPRD   = 4'd6,  // read top of stack
    DC_SLOTRD  = 4'd7,  // read slot of top cursor
    DC_VISIT   = 4'd8,  // test target, advance cursor, maybe push
    DC_EMIT    = 4'd9   // read marks for output
  } dcmd_t;

  typedef struct packed {
    dcmd_t      cmd;
    logic       sel_b;     // append direction b->a
    logic       scan_rst;  // reset scan counter
  } ctrl_t;

  typedef struct packed {
    logic scan_done;
    logic stack_empty;
    logic top_more;
    logic emit_last;
  } stat_t;

endpackage

// ----- hw/rtl/gdfs_datapath.sv -----
// Datapath: adjacency memories, marks, walk stack and result fields.
// Depends on gdfs_pkg.
module gdfs_datapath
  import gdfs_pkg::*;
#(
  parameter int MAX_VERTICES   = 64,
  parameter int MAX_EDGE_SLOTS = 512,
  localparam int VW = $clog2(MAX_VERTICES),
  localparam int SW = $clog2(MAX_EDGE_SLOTS),
  localparam int DW = $clog2(MAX_VERTICES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  ctrl_t         ctrl,
  input  logic [5:0]    va,
  input  logic [5:0]    vb,
  input  logic [6:0]    n_live,
  output stat_t         stat,
  output logic [5:0]    out_id,
  output logic [6:0]    out_parent,
  output logic          out_visited,
  output logic [SW:0]   used
);

  logic [SW-1:0] head_mem [MAX_VERTICES];
  logic [SW-1:0] tail_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] filled;
  logic [MAX_VERTICES-1:0] reached;
  logic [MAX_VERTICES-1:0] parented;
  logic [6:0]    came_mem [MAX_VERTICES];
  logic [SW-1:0] next_mem [MAX_EDGE_SLOTS];
  logic [5:0]    tgt_mem  [MAX_EDGE_SLOTS];
  logic [VW-1:0] stk_vtx  [MAX_VERTICES];
  logic [SW-1:0] stk_cur  [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] stk_more;
  logic [DW-1:0] depth;
  logic [6:0]    scan;
  logic [VW-1:0] top_v;
  logic [SW-1:0] top_c;
  logic          top_m;
  logic [SW-1:0] cur_next;
  logic [5:0]    cur_tgt;
  logic [SW-1:0] tail_rd;
  logic [SW-1:0] new_slot;
  logic [VW-1:0] from_v, to_v, scan_v, top_idx;
  logic [6:0]    came_rd;
  logic          par_q;

  assign from_v  = ctrl.sel_b ? vb[VW-1:0] : va[VW-1:0];
  assign to_v    = ctrl.sel_b ? va[VW-1:0] : vb[VW-1:0];
  assign scan_v  = scan[VW-1:0];
  assign top_idx = VW'(depth - DW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= '0;
    end else if (ctrl.scan_rst) begin
      scan <= '0;
    end else if (ctrl.cmd == DC_WIPE || ctrl.cmd == DC_WIPEMK || ctrl.cmd == DC_EMIT) begin
      scan <= scan + 7'd1;
    end
  end

  assign stat.scan_done = (ctrl.cmd == DC_EMIT) ? (scan + 7'd1 >= n_live)
                                                : (scan == 7'(MAX_VERTICES - 1));
  assign stat.emit_last = (scan + 7'd1 >= n_live);
  assign stat.stack_empty = (depth == '0);
  assign stat.top_more = top_m;

  // valid-bit style control state: filled, reached, parented, used, depth
  always_ff @(posedge clk) begin
    if (rst) begin
      filled   <= '0;
      reached  <= '0;
      parented <= '0;
      used     <= '0;
      depth    <= '0;
    end else begin
      case (ctrl.cmd)
        DC_WIPE: begin
          filled[scan_v]   <= 1'b0;
          reached[scan_v]  <= 1'b0;
          parented[scan_v] <= 1'b0;
          used <= '0;
        end
        DC_WIPEMK: begin
          reached[scan_v]  <= 1'b0;
          parented[scan_v] <= 1'b0;
        end
        DC_LINK: begin
          filled[from_v] <= 1'b1;
          used <= used + (SW+1)'(1);
        end
        DC_SRCMARK: begin
          reached[va[VW-1:0]] <= 1'b1;
          depth <= DW'(1);
        end
        DC_VISIT: begin
          if (!top_m) begin
            depth <= depth - DW'(1);
          end else if ({1'b0, cur_tgt} < n_live && !reached[cur_tgt[VW-1:0]]
                       && depth < DW'(MAX_VERTICES)) begin
            reached[cur_tgt[VW-1:0]]  <= 1'b1;
            parented[cur_tgt[VW-1:0]] <= 1'b1;
            depth <= depth + DW'(1);
          end else if ({1'b0, cur_tgt} < n_live && !reached[cur_tgt[VW-1:0]]) begin
            reached[cur_tgt[VW-1:0]]  <= 1'b1;
            parented[cur_tgt[VW-1:0]] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign new_slot = used[SW-1:0];

  always_ff @(posedge clk) begin
    tail_rd <= tail_mem[(ctrl.cmd == DC_SLOTRD) ? top_v : from_v];
    case (ctrl.cmd)
      DC_WIPE: came_mem[scan_v] <= NO_PARENT;
      DC_WIPEMK: came_mem[scan_v] <= NO_PARENT;
      DC_APPEND: begin
        tgt_mem[new_slot]  <= to_v[5:0] ;
        next_mem[new_slot] <= '0;
      end
      DC_LINK: begin
        if (filled[from_v]) next_mem[tail_rd] <= new_slot;
        else head_mem[from_v] <= new_slot;
        tail_mem[from_v] <= new_slot;
      end
      DC_SRCMARK: begin
        stk_vtx[0] <= va[VW-1:0];
        stk_cur[0] <= head_mem[va[VW-1:0]];
        stk_more[0] <= filled[va[VW-1:0]];
      end
      DC_TOPRD: begin
        top_v <= stk_vtx[top_idx];
        top_c <= stk_cur[top_idx];
        top_m <= stk_more[top_idx];
      end
      DC_SLOTRD: begin
        cur_next <= next_mem[top_c];
        cur_tgt  <= tgt_mem[top_c];
      end
      DC_VISIT: begin
        if (top_m) begin
          if (top_c == tail_rd) stk_more[top_idx] <= 1'b0;
          else stk_cur[top_idx] <= cur_next;
          if ({1'b0, cur_tgt} < n_live && !reached[cur_tgt[VW-1:0]]) begin
            came_mem[cur_tgt[VW-1:0]] <= 7'(top_v);
            if (depth < DW'(MAX_VERTICES)) begin
              stk_vtx[depth[VW-1:0]]  <= cur_tgt[VW-1:0];
              stk_cur[depth[VW-1:0]]  <= head_mem[cur_tgt[VW-1:0]];
              stk_more[depth[VW-1:0]] <= filled[cur_tgt[VW-1:0]];
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    came_rd <= came_mem[scan_v];
    par_q   <= parented[scan_v];
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmd == DC_EMIT) begin
      out_id      <= 6'(scan);
      out_visited <= reached[scan_v];
    end
  end
  assign out_parent = par_q ? came_rd : NO_PARENT;

endmodule

// ----- hw/rtl/gdfs_ctrl.sv -----
// Controller state machine sequencing the datapath per operation.
// Depends on gdfs_pkg.
module gdfs_ctrl
  import gdfs_pkg::*;
#(
  parameter int MAX_EDGE_SLOTS = 512,
  localparam int SW = $clog2(MAX_EDGE_SLOTS)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_take,
  input  logic [1:0]  op_in,
  input  logic [5:0]  va,
  input  logic [5:0]  vb,
  input  logic [6:0]  n_live,
  input  logic        directed,
  input  logic [SW:0] used,
  input  stat_t       stat,
  input  logic        out_free,
  output ctrl_t       ctrl,
  output logic        busy,
  output logic        res_load,
  output status_t     res_status,
  output logic        res_search,
  output logic        res_last
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_WIPE   = 10'b0000000010,
    S_WIPEMK = 10'b0000000100,
    S_APP    = 10'b0000001000,
    S_LINK   = 10'b0000010000,
    S_TOP    = 10'b0000100000,
    S_SLOT   = 10'b0001000000,
    S_VISIT  = 10'b0010000000,
    S_EMIT   = 10'b0100000000,
    S_EMITW  = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   second, second_next;
  logic   emit_last_q;

  always_comb begin
    state_next  = state;
    second_next = second;
    ctrl = '{cmd: DC_NONE, sel_b: second, scan_rst: 1'b0};
    res_load = 1'b0;
    res_status = ST_OK;
    res_search = 1'b0;
    res_last = 1'b1;
    case (state)
      S_IDLE: begin
        ctrl.scan_rst = 1'b1;
        if (in_take) begin
          case (op_t'(op_in))
            OP_CLEAR_GRAPH: state_next = S_WIPE;
            OP_CLEAR_MARKS: state_next = S_WIPEMK;
            OP_ADD_EDGE: begin
              if ({1'b0, va} >= n_live || {1'b0, vb} >= n_live) begin
                res_load = 1'b1; res_status = ST_RANGE;
              end else if (used + (directed ? (SW+1)'(1) : (SW+1)'(2))
                           > (SW+1)'(MAX_EDGE_SLOTS)) begin
                res_load = 1'b1; res_status = ST_FULL;
              end else begin
                second_next = 1'b0;
                state_next = S_APP;
              end
            end
            default: begin
              if ({1'b0, va} >= n_live) begin
                res_load = 1'b1; res_status = ST_RANGE;
              end else begin
                ctrl.cmd = DC_SRCMARK;
                state_next = S_TOP;
              end
            end
          endcase
        end
      end
      S_WIPE: begin
        ctrl.cmd = DC_WIPE;
        if (stat.scan_done) begin
          res_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_WIPEMK: begin
        ctrl.cmd = DC_WIPEMK;
        if (stat.scan_done) begin
          res_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_APP: begin
        ctrl.cmd = DC_APPEND;
        state_next = S_LINK;
      end
      S_LINK: begin
        ctrl.cmd = DC_LINK;
        if (!second && !directed) begin
          second_next = 1'b1;
          state_next = S_APP;
        end else begin
          res_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_TOP: begin
        if (stat.stack_empty) begin
          ctrl.scan_rst = 1'b1;
          state_next = S_EMIT;
        end else begin
          ctrl.cmd = DC_TOPRD;
          state_next = S_SLOT;
        end
      end
      S_SLOT: begin
        ctrl.cmd = DC_SLOTRD;
        state_next = S_VISIT;
      end
      S_VISIT: begin
        ctrl.cmd = DC_VISIT;
        state_next = S_TOP;
      end
      S_EMIT: begin
        if (out_free) begin
          ctrl.cmd = DC_EMIT;
          state_next = S_EMITW;
        end
      end
      S_EMITW: begin
        res_load = 1'b1;
        res_search = 1'b1;
        res_last = emit_last_q;
        state_next = emit_last_q ? S_IDLE : S_EMIT;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmd == DC_EMIT) emit_last_q <= stat.emit_last;
  end

  // Accept a new item only when idle and the result register is free.
  assign busy = (state != S_IDLE) || !out_free;

endmodule

// ----- hw/rtl/graph_depth_first_search_core.sv -----
// Depth-first search core: top level joining controller and datapath.
// Depends on gdfs_pkg, gdfs_ctrl, gdfs_datapath.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------------
//  in      | in_valid  | in_stall  | op, vertex_a, vertex_b
//  out     | out_valid | out_stall | status, vertex_id, parent, visited, last
//  cfg     | cfg_we    | -         | cfg_index, cfg_data
//
// Add edge: append then link, once (directed) or twice (undirected); clear ops
// sweep every vertex. Search: each stack step reads the top, its slot, then
// visits (one per edge visited plus one per pop); then a result per vertex.
// Reset (synchronous) empties all lists and marks at once via valid bits.
// out_stall holds the result register; the next item waits for it to drain.
module graph_depth_first_search_core
  import gdfs_pkg::*;
#(
  parameter int MAX_VERTICES   = 64,
  parameter int MAX_EDGE_SLOTS = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [5:0]  vertex_a,
  input  logic [5:0]  vertex_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [5:0]  vertex_id,
  output logic signed [6:0] parent,
  output logic        visited,
  output logic        last
);

  localparam int SW = $clog2(MAX_EDGE_SLOTS);

  logic [6:0]  vertex_count;
  logic        directed_mode;
  logic [6:0]  n_live;
  logic [5:0]  va, vb;
  logic        in_take, busy, res_load, res_search, res_last, out_free;
  status_t     res_status;
  ctrl_t       ctrl;
  stat_t       stat;
  logic [5:0]  dp_id;
  logic [6:0]  dp_parent;
  logic        dp_visited;
  logic [SW:0] used;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= 7'd64;
      directed_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VERTEX_COUNT:  vertex_count <= cfg_data;
        REG_DIRECTED_MODE: directed_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign n_live = (vertex_count == 7'd0) ? 7'd1 :
                  (vertex_count > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vertex_count;

  assign in_stall = busy;
  assign in_take  = in_valid && !busy;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (in_take) begin
      va <= vertex_a;
      vb <= vertex_b;
    end
  end

  gdfs_ctrl #(.MAX_EDGE_SLOTS(MAX_EDGE_SLOTS)) u_ctrl (
    .clk, .rst, .in_take, .op_in(op), .va(vertex_a), .vb(vertex_b), .n_live,
    .directed(directed_mode), .used, .stat, .out_free, .ctrl, .busy,
    .res_load, .res_status, .res_search, .res_last
  );

  gdfs_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGE_SLOTS(MAX_EDGE_SLOTS)) u_dp (
    .clk, .rst, .ctrl, .va(ctrl.cmd == DC_SRCMARK ? vertex_a : va), .vb, .n_live,
    .stat, .out_id(dp_id), .out_parent(dp_parent), .out_visited(dp_visited), .used
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status    <= res_status;
      vertex_id <= res_search ? dp_id : 6'd0;
      parent    <= res_search ? dp_parent : NO_PARENT;
      visited   <= res_search ? dp_visited : 1'b0;
      last      <= res_last;
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !res_load) else $error("result overwritten");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(vertex_id)
    && $stable(parent) && $stable(visited) && $stable(last))
    else $error("stalled result changed");
  a_slots_bound: assert property (@(posedge clk) disable iff (rst)
    used <= (SW+1)'(MAX_EDGE_SLOTS)) else $error("slot count overflow");
`endif

endmodule
